### hdl/pidd_pkg.sv
package pidd_pkg;

    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 31;
    localparam int CFG_IDX_W = 3;
    localparam int FRAC_W    = 16;
    localparam int MUL_A_W   = 35;
    localparam int MUL_MAG_W = 34;
    localparam int MUL_HALF_W = 17;
    localparam int MUL_PP_W  = MUL_HALF_W + GAIN_W;
    localparam int MUL_ACC_W = MUL_PP_W + MUL_HALF_W;
    localparam int MUL_RES_W = 50;
    localparam int SUM_W     = 36;
    localparam int DIV_Q_W   = 16;
    localparam int FACT_W    = DIV_Q_W + 1;

    // derivative smoothing g, Q0.16
    localparam logic [FRAC_W-1:0] DERIV_SMOOTHING_Q16 = 16'd0;
    localparam logic [FACT_W-1:0] FACT_ONE    = 17'h1_0000;
    localparam logic [FACT_W-1:0] SMOOTH_KEEP = FACT_ONE - FACT_W'(DERIV_SMOOTHING_Q16);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE             = 3'd0,
        REG_PROP_GAIN        = 3'd1,
        REG_INTEG_GAIN       = 3'd2,
        REG_DERIV_GAIN       = 3'd3,
        REG_OUTPUT_LIMIT     = 3'd4,
        REG_INTEGRAL_LIMIT   = 3'd5,
        REG_SEPARATION_LIMIT = 3'd6,
        REG_DEAD_BAND        = 3'd7
    } t_cfg_reg;

    typedef enum logic [2:0] {
        MOP_P  = 3'd0,
        MOP_I  = 3'd1,
        MOP_D  = 3'd2,
        MOP_S1 = 3'd3,
        MOP_S2 = 3'd4,
        MOP_IF = 3'd5
    } t_mop;

    typedef enum logic [2:0] {
        S_IDLE     = 3'd0,
        S_ERR      = 3'd1,
        S_MUL_GO   = 3'd2,
        S_MUL_WAIT = 3'd3,
        S_DIV_GO   = 3'd4,
        S_DIV_WAIT = 3'd5,
        S_INTEG    = 3'd6,
        S_OUT      = 3'd7
    } t_state;

    typedef enum logic [1:0] {
        MS_IDLE = 2'd0,
        MS_LO   = 2'd1,
        MS_HI   = 2'd2,
        MS_RND  = 2'd3
    } t_mul_step;

    typedef struct packed {
        logic load;
        logic calc_err;
        logic mul_start;
        logic mul_store;
        t_mop op;
        logic div_start;
        logic fin_integ;
        logic fin_out;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic mul_done;
        logic div_done;
    } t_status;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [MUL_RES_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[MUL_RES_W-1:DATA_W-1] == '0 || v[MUL_RES_W-1:DATA_W-1] == '1) begin
            r = v[DATA_W-1:0];
        end else if (v[MUL_RES_W-1]) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp_sym(input logic signed [SUM_W-1:0] v,
                                                          input logic [GAIN_W-1:0] lim);
        logic signed [SUM_W-1:0] l;
        logic signed [SUM_W-1:0] r;
        l = signed'(SUM_W'(lim));
        if (v > l) begin
            r = l;
        end else if (v < -l) begin
            r = -l;
        end else begin
            r = v;
        end
        return r[DATA_W-1:0];
    endfunction

endpackage

### hdl/pidd_mul.sv
module pidd_mul (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [pidd_pkg::MUL_A_W-1:0]   i_a,
    input  logic        [pidd_pkg::GAIN_W-1:0]    i_b,
    input  logic                                  i_sh17,
    output logic                                  o_done,
    output logic signed [pidd_pkg::MUL_RES_W-1:0] o_res
);
    pidd_pkg::t_mul_step                  r_step;
    logic                                 r_done;
    logic [pidd_pkg::MUL_MAG_W-1:0]       r_mag;
    logic                                 r_neg;
    logic [pidd_pkg::GAIN_W-1:0]          r_b;
    logic                                 r_sh17;
    logic [pidd_pkg::MUL_ACC_W-1:0]       r_acc;
    logic signed [pidd_pkg::MUL_RES_W-1:0] r_res;

    logic [pidd_pkg::MUL_HALF_W-1:0]      w_half;
    logic [pidd_pkg::MUL_PP_W-1:0]        w_pp;
    logic [pidd_pkg::MUL_ACC_W:0]         w_rnd;
    logic [pidd_pkg::MUL_ACC_W:0]         w_shr;
    logic signed [pidd_pkg::MUL_RES_W-1:0] w_mag;

    assign w_half = (r_step == pidd_pkg::MS_HI) ?
                    r_mag[pidd_pkg::MUL_MAG_W-1:pidd_pkg::MUL_HALF_W] :
                    r_mag[pidd_pkg::MUL_HALF_W-1:0];
    assign w_pp   = pidd_pkg::MUL_PP_W'(w_half) * pidd_pkg::MUL_PP_W'(r_b);
    assign w_rnd  = {1'b0, r_acc} + (r_sh17 ? (pidd_pkg::MUL_ACC_W+1)'(1) << pidd_pkg::FRAC_W :
                                     (pidd_pkg::MUL_ACC_W+1)'(1) << (pidd_pkg::FRAC_W - 1));
    assign w_shr  = r_sh17 ? (w_rnd >> (pidd_pkg::FRAC_W + 1)) : (w_rnd >> pidd_pkg::FRAC_W);
    assign w_mag  = signed'({1'b0, w_shr[pidd_pkg::MUL_RES_W-2:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= pidd_pkg::MS_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_step)
                pidd_pkg::MS_IDLE: begin
                    if (i_start) begin
                        r_step <= pidd_pkg::MS_LO;
                    end
                end
                pidd_pkg::MS_LO:  r_step <= pidd_pkg::MS_HI;
                pidd_pkg::MS_HI:  r_step <= pidd_pkg::MS_RND;
                pidd_pkg::MS_RND: begin
                    r_step <= pidd_pkg::MS_IDLE;
                    r_done <= 1'b1;
                end
                default: r_step <= pidd_pkg::MS_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_step == pidd_pkg::MS_IDLE && i_start) begin
            r_mag  <= i_a[pidd_pkg::MUL_A_W-1] ? pidd_pkg::MUL_MAG_W'(-i_a) :
                                                 pidd_pkg::MUL_MAG_W'(i_a);
            r_neg  <= i_a[pidd_pkg::MUL_A_W-1];
            r_b    <= i_b;
            r_sh17 <= i_sh17;
        end
        if (r_step == pidd_pkg::MS_LO) begin
            r_acc <= pidd_pkg::MUL_ACC_W'(w_pp);
        end
        if (r_step == pidd_pkg::MS_HI) begin
            r_acc <= r_acc + {w_pp, {pidd_pkg::MUL_HALF_W{1'b0}}};
        end
        if (r_step == pidd_pkg::MS_RND) begin
            r_res <= r_neg ? -w_mag : w_mag;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

### hdl/pidd_div.sv
module pidd_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [pidd_pkg::GAIN_W-1:0]        i_num,
    input  logic [pidd_pkg::GAIN_W-1:0]        i_den,
    output logic                               o_done,
    output logic [pidd_pkg::DIV_Q_W-1:0]       o_quo
);
    localparam int CNT_W = $clog2(pidd_pkg::DIV_Q_W + 1);

    logic                             r_busy;
    logic                             r_done;
    logic [CNT_W-1:0]                 r_cnt;
    logic [pidd_pkg::GAIN_W:0]        r_rem;
    logic [pidd_pkg::GAIN_W-1:0]      r_den;
    logic [pidd_pkg::DIV_Q_W-1:0]     r_quo;

    logic [pidd_pkg::GAIN_W:0]        w_sh;
    logic                             w_ge;

    assign w_sh = {r_rem[pidd_pkg::GAIN_W-1:0], 1'b0};
    assign w_ge = w_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(pidd_pkg::DIV_Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_sh - {1'b0, r_den}) : w_sh;
            r_quo <= {r_quo[pidd_pkg::DIV_Q_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

### hdl/pidd_datapath.sv
module pidd_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pidd_pkg::t_cmd                      i_cmd,
    output pidd_pkg::t_status                   o_status,
    input  logic                                i_cfg_we,
    input  logic [pidd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pidd_pkg::GAIN_W-1:0]         i_cfg_data,
    input  logic signed [pidd_pkg::DATA_W-1:0]  i_measured,
    input  logic signed [pidd_pkg::DATA_W-1:0]  i_target,
    output logic signed [pidd_pkg::DATA_W-1:0]  o_drive
);
    localparam int DW = pidd_pkg::DATA_W;
    localparam int GW = pidd_pkg::GAIN_W;
    localparam int AW = pidd_pkg::MUL_A_W;
    localparam int RW = pidd_pkg::MUL_RES_W;
    localparam int SW = pidd_pkg::SUM_W;

    logic           r_mode;
    logic [GW-1:0]  r_kp, r_ki, r_kd, r_olim, r_ilim, r_sep, r_db;

    logic signed [DW-1:0] r_meas, r_tgt, r_e;
    logic [DW-1:0]        r_ae;
    logic signed [DW-1:0] r_e1, r_e2, r_integ, r_lastd, r_acc;
    logic signed [DW-1:0] r_p, r_ia, r_a, r_d, r_i, r_drive;
    logic signed [RW-1:0] r_s1;

    logic signed [DW:0]   w_diff;
    logic signed [DW-1:0] w_esat;
    logic [DW-1:0]        w_aesat;
    logic signed [AW-1:0] w_e, w_e1, w_e2, w_ma;
    logic [GW-1:0]        w_mb;
    logic                 w_sh17;
    logic [pidd_pkg::FACT_W-1:0] w_f;
    logic                 w_mdone, w_ddone;
    logic signed [RW-1:0] w_mres;
    logic [pidd_pkg::DIV_Q_W-1:0] w_quo;
    logic signed [SW-1:0] w_isum, w_osum;

    assign w_diff  = {r_tgt[DW-1], r_tgt} - {r_meas[DW-1], r_meas};
    assign w_esat  = (w_diff[DW] != w_diff[DW-1]) ?
                     (w_diff[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}}) :
                     w_diff[DW-1:0];
    assign w_aesat = w_esat[DW-1] ? (DW'(0) - DW'(w_esat)) : DW'(w_esat);

    assign w_e  = AW'(r_e);
    assign w_e1 = AW'(r_e1);
    assign w_e2 = AW'(r_e2);

    assign w_f = (r_ae == '0) ? pidd_pkg::FACT_ONE :
                 (r_ae > DW'(r_sep)) ? '0 : pidd_pkg::FACT_W'(w_quo);

    always_comb begin
        w_ma   = w_e;
        w_mb   = r_kp;
        w_sh17 = 1'b0;
        unique case (i_cmd.op)
            pidd_pkg::MOP_P: begin
                w_ma = r_mode ? (w_e - w_e1) : w_e;
                w_mb = r_kp;
            end
            pidd_pkg::MOP_I: begin
                w_ma = r_mode ? (w_e + w_e1) : w_e;
                w_mb = r_ki;
            end
            pidd_pkg::MOP_D: begin
                w_ma = r_mode ? (w_e - (w_e1 <<< 1) + w_e2) : (w_e - w_e1);
                w_mb = r_kd;
            end
            pidd_pkg::MOP_S1: begin
                w_ma = AW'(r_a);
                w_mb = GW'(pidd_pkg::SMOOTH_KEEP);
            end
            pidd_pkg::MOP_S2: begin
                w_ma = AW'(r_lastd);
                w_mb = GW'(pidd_pkg::DERIV_SMOOTHING_Q16);
            end
            pidd_pkg::MOP_IF: begin
                w_ma   = AW'(r_ia);
                w_mb   = GW'(w_f);
                w_sh17 = 1'b1;
            end
            default: begin
                w_ma = w_e;
            end
        endcase
    end

    assign w_isum = SW'(r_integ) + ((r_ae < DW'(r_sep)) ? SW'(r_ia) : SW'(0));
    assign w_osum = r_mode ? (SW'(r_acc) + SW'(r_p) + SW'(r_i) + SW'(r_d)) :
                             (SW'(r_p) + SW'(r_integ) + SW'(r_d));

    pidd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .i_sh17  (w_sh17),
        .o_done  (w_mdone),
        .o_res   (w_mres)
    );

    pidd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (GW'(DW'(r_sep) - r_ae)),
        .i_den   (r_sep),
        .o_done  (w_ddone),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_kp    <= '0;
            r_ki    <= '0;
            r_kd    <= '0;
            r_olim  <= '1;
            r_ilim  <= '1;
            r_sep   <= '1;
            r_db    <= '0;
            r_e1    <= '0;
            r_e2    <= '0;
            r_integ <= '0;
            r_lastd <= '0;
            r_acc   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (pidd_pkg::t_cfg_reg'(i_cfg_idx))
                    pidd_pkg::REG_MODE:             r_mode <= i_cfg_data[0];
                    pidd_pkg::REG_PROP_GAIN:        r_kp   <= i_cfg_data;
                    pidd_pkg::REG_INTEG_GAIN:       r_ki   <= i_cfg_data;
                    pidd_pkg::REG_DERIV_GAIN:       r_kd   <= i_cfg_data;
                    pidd_pkg::REG_OUTPUT_LIMIT:     r_olim <= i_cfg_data;
                    pidd_pkg::REG_INTEGRAL_LIMIT:   r_ilim <= i_cfg_data;
                    pidd_pkg::REG_SEPARATION_LIMIT: r_sep  <= i_cfg_data;
                    pidd_pkg::REG_DEAD_BAND:        r_db   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.fin_integ) begin
                r_integ <= r_mode ? r_i : pidd_pkg::clamp_sym(w_isum, r_ilim);
            end
            if (i_cmd.fin_out) begin
                r_acc   <= pidd_pkg::clamp_sym(w_osum, r_olim);
                r_lastd <= r_d;
                r_e2    <= r_e1;
                r_e1    <= r_e;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_meas <= i_measured;
            r_tgt  <= i_target;
        end
        if (i_cmd.calc_err) begin
            if (w_aesat < DW'(r_db)) begin
                r_e  <= '0;
                r_ae <= '0;
            end else begin
                r_e  <= w_esat;
                r_ae <= w_aesat;
            end
        end
        if (i_cmd.mul_store) begin
            unique case (i_cmd.op)
                pidd_pkg::MOP_P:  r_p  <= pidd_pkg::sat32(w_mres);
                pidd_pkg::MOP_I:  r_ia <= pidd_pkg::sat32(w_mres);
                pidd_pkg::MOP_D: begin
                    r_a <= pidd_pkg::sat32(w_mres);
                    r_d <= pidd_pkg::sat32(w_mres);
                end
                pidd_pkg::MOP_S1: r_s1 <= w_mres;
                pidd_pkg::MOP_S2: r_d  <= pidd_pkg::sat32(r_s1 + w_mres);
                pidd_pkg::MOP_IF: r_i  <= w_mres[DW-1:0];
                default: ;
            endcase
        end
        if (i_cmd.fin_out) begin
            r_drive <= pidd_pkg::clamp_sym(w_osum, r_olim);
        end
    end

    assign o_status.mode     = r_mode;
    assign o_status.mul_done = w_mdone;
    assign o_status.div_done = w_ddone;
    assign o_drive           = r_drive;

endmodule

### hdl/pidd_ctrl.sv
module pidd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  pidd_pkg::t_status i_status,
    output pidd_pkg::t_cmd    o_cmd
);
    pidd_pkg::t_state r_state, n_state;
    pidd_pkg::t_mop   r_op, n_op;
    logic             r_out_valid, n_out_valid;
    logic             w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pidd_pkg::S_IDLE;
            r_op        <= pidd_pkg::MOP_P;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.op    = r_op;
        unique case (r_state)
            pidd_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = pidd_pkg::S_ERR;
                end
            end
            pidd_pkg::S_ERR: begin
                o_cmd.calc_err = 1'b1;
                n_op           = pidd_pkg::MOP_P;
                n_state        = pidd_pkg::S_MUL_GO;
            end
            pidd_pkg::S_MUL_GO: begin
                o_cmd.mul_start = 1'b1;
                n_state         = pidd_pkg::S_MUL_WAIT;
            end
            pidd_pkg::S_MUL_WAIT: begin
                if (i_status.mul_done) begin
                    o_cmd.mul_store = 1'b1;
                    unique case (r_op)
                        pidd_pkg::MOP_P: begin
                            n_op    = pidd_pkg::MOP_I;
                            n_state = pidd_pkg::S_MUL_GO;
                        end
                        pidd_pkg::MOP_I: begin
                            n_op    = pidd_pkg::MOP_D;
                            n_state = pidd_pkg::S_MUL_GO;
                        end
                        pidd_pkg::MOP_D: begin
                            n_op    = pidd_pkg::MOP_S1;
                            n_state = i_status.mode ? pidd_pkg::S_DIV_GO : pidd_pkg::S_MUL_GO;
                        end
                        pidd_pkg::MOP_S1: begin
                            n_op    = pidd_pkg::MOP_S2;
                            n_state = pidd_pkg::S_MUL_GO;
                        end
                        default: begin
                            n_state = pidd_pkg::S_INTEG;
                        end
                    endcase
                end
            end
            pidd_pkg::S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = pidd_pkg::S_DIV_WAIT;
            end
            pidd_pkg::S_DIV_WAIT: begin
                if (i_status.div_done) begin
                    n_op    = pidd_pkg::MOP_IF;
                    n_state = pidd_pkg::S_MUL_GO;
                end
            end
            pidd_pkg::S_INTEG: begin
                o_cmd.fin_integ = 1'b1;
                n_state         = pidd_pkg::S_OUT;
            end
            pidd_pkg::S_OUT: begin
                if (w_out_free) begin
                    o_cmd.fin_out = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = pidd_pkg::S_IDLE;
                end
            end
            default: n_state = pidd_pkg::S_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != pidd_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### hdl/pid_controller_dual_mode.sv
// Dual-mode PID controller, Q16.16, positional or incremental form.
// Input channel: i_in_valid / o_in_stall carry i_measured and i_target; a
// transfer happens on a rising edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall carry o_drive, one result per input.
// Config: write i_cfg_data into register i_cfg_idx while i_cfg_we is high,
// only while the block is idle.
// Work: positional runs the error step, 5 multiplies, then the integral and
// output steps; incremental has 4 multiplies plus the 16-step radix-2 divide
// of the integral fade factor. One item in flight; the next is taken only once
// the result of the one before is posted. The work is serialised on the shared
// 17x31 multiplier and the bit-serial divider.
// Reset (synchronous, active low): gains and dead band 0, limits all ones,
// history and accumulators cleared, output register empty.
// A stalled result holds in the output register; the next input is still
// taken and computed, and then waits for the register to empty.
module pid_controller_dual_mode (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [pidd_pkg::DATA_W-1:0]  i_measured,
    input  logic signed [pidd_pkg::DATA_W-1:0]  i_target,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [pidd_pkg::DATA_W-1:0]  o_drive,
    input  logic                                i_cfg_we,
    input  logic [pidd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pidd_pkg::GAIN_W-1:0]         i_cfg_data
);
    pidd_pkg::t_cmd    w_cmd;
    pidd_pkg::t_status w_status;

    pidd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    pidd_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_measured (i_measured),
        .i_target   (i_target),
        .o_drive    (o_drive)
    );

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while item in work");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result posted with no item in work");

    a_symmetric_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_drive != {1'b1, {(pidd_pkg::DATA_W-1){1'b0}}})
        else $error("drive outside symmetric range");

endmodule
